// ----- design/assert_macros.svh -----
// assertion macros shared by the flow tracker modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold whenever reset is released
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- design/fct_pkg.sv -----
// shared constants and types for the flow congestion tracker
// no dependencies
`default_nettype none
package fct_pkg;
    localparam int unsigned FlowEntries = 1024;
    localparam logic [15:0] MinFrameBytes = 16'd54;
    localparam logic [7:0]  ProtoTcp = 8'd6;
    localparam logic [31:0] RstIntervalLimit = 32'd1000000;
    localparam logic [7:0]  RstRetransmitLimit = 8'd3;
    localparam logic [31:0] RstNotifyLimit = 32'd10;
    localparam logic [63:0] RstHoldTime = 64'd10000000000;
    localparam logic [15:0] RstWatchedPort = 16'd1935;
    localparam logic [15:0] RstInitialWindow = 16'd10;

    localparam logic [2:0] CfgIntervalLimit = 3'd0;
    localparam logic [2:0] CfgRetransmitLimit = 3'd1;
    localparam logic [2:0] CfgNotifyLimit = 3'd2;
    localparam logic [2:0] CfgHoldTime = 3'd3;
    localparam logic [2:0] CfgWatchedPort = 3'd4;
    localparam logic [2:0] CfgInitialWindow = 3'd5;

    // classified request from the front to the back
    typedef struct packed {
        logic        watch;
        logic [31:0] key;
        logic        flagged;
        logic [63:0] now;
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SEARCH, ST_READ, ST_CALC, ST_WRITE, ST_OUT
    } t_state;

    typedef struct packed {
        logic [63:0] last_time;
        logic [31:0] normal;
        logic [31:0] flagged;
        logic [63:0] start;
        logic [31:0] window;
        logic        wset;
    } t_entry;
endpackage
`default_nettype wire

// ----- design/fct_front.sv -----
// front end: classifies packets against the watch filter into a two-entry queue
// depends on fct_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module fct_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [15:0]   i_frame_length,
    input  wire logic [7:0]    i_ip_protocol,
    input  wire logic [31:0]   i_source_address,
    input  wire logic [15:0]   i_source_port,
    input  wire logic [15:0]   i_dest_port,
    input  wire logic          i_flag,
    input  wire logic [63:0]   i_time_ns,
    input  wire logic [15:0]   i_watched_port,
    output logic               o_req_valid,
    input  wire logic          i_req_ready,
    output fct_pkg::t_req      o_req
);
    fct_pkg::t_req r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push, pop;
    fct_pkg::t_req cls;

    // classification
    always_comb begin
        cls.watch = (i_frame_length >= fct_pkg::MinFrameBytes) &&
                    (i_ip_protocol == fct_pkg::ProtoTcp) &&
                    ((i_source_port == i_watched_port) || (i_dest_port == i_watched_port));
        cls.key = i_source_address;
        cls.flagged = i_flag;
        cls.now = i_time_ns;
    end

    assign o_ready = (r_cnt != 2'd2);
    assign push = i_valid && o_ready;
    assign o_req_valid = (r_cnt != 2'd0);
    assign pop = o_req_valid && i_req_ready;
    assign o_req = r_q[r_rp];

    // queue payload
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= cls;
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    `CHK_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3, "queue count out of range")
    `CHK_NEXT(a_full_hold, i_clk, i_rst_n, (r_cnt == 2'd2) && !pop, r_cnt == 2'd2, "full queue lost an item")
    `CHK_NEXT(a_push_kept, i_clk, i_rst_n, push, r_cnt != 2'd0, "pushed request not queued")
endmodule
`default_nettype wire

// ----- design/fct_back.sv -----
// back end: flow table search, read-modify-write and result register
// depends on fct_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module fct_back #(
    parameter int unsigned FLOW_ENTRIES = fct_pkg::FlowEntries
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire fct_pkg::t_req i_req,
    input  wire logic [31:0]   i_interval_limit,
    input  wire logic [7:0]    i_retransmit_limit,
    input  wire logic [31:0]   i_notify_limit,
    input  wire logic [63:0]   i_hold_time,
    input  wire logic [15:0]   i_initial_window,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [130:0]       o_data
);
    localparam int AW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CW = $clog2(FLOW_ENTRIES + 1);
    localparam logic [CW-1:0] Full = CW'(FLOW_ENTRIES);

    logic [31:0]         m_key [FLOW_ENTRIES];
    fct_pkg::t_entry     m_ent [FLOW_ENTRIES];

    fct_pkg::t_state r_state, n_state;
    fct_pkg::t_req   r_req;
    logic [CW-1:0]   r_used;
    logic [CW-1:0]   r_idx;
    logic [31:0]     r_keyrd;
    logic [AW-1:0]   r_slot;
    logic            r_hit, r_new;
    fct_pkg::t_entry r_ent, r_upd;
    logic [31:0]     r_notify;
    logic            r_cong;
    logic            r_outv;
    logic [130:0]    r_out;

    logic          take, hit_now, out_fire;
    logic [63:0]   gap, held;
    logic [31:0]   nn, nf, w2;
    logic          cong;
    logic [31:0]   ninc;
    fct_pkg::t_entry e, upd;

    assign take = i_req_valid && o_req_ready;
    // key read last cycle belongs to the entry just below r_idx
    assign hit_now = (r_state == fct_pkg::ST_SEARCH) && r_req.watch && !r_hit &&
                     (r_idx != '0) && (r_keyrd == r_req.key);

    // state outputs
    always_comb begin
        o_req_ready = (r_state == fct_pkg::ST_IDLE);
        out_fire = (r_state == fct_pkg::ST_OUT) && (!r_outv || i_ready);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fct_pkg::ST_IDLE:
                if (take) n_state = fct_pkg::ST_SEARCH;
            fct_pkg::ST_SEARCH:
                if (!r_req.watch) n_state = fct_pkg::ST_OUT;
                else if (hit_now || r_idx >= r_used) n_state = fct_pkg::ST_READ;
            fct_pkg::ST_READ:  n_state = fct_pkg::ST_CALC;
            fct_pkg::ST_CALC:  n_state = fct_pkg::ST_WRITE;
            fct_pkg::ST_WRITE: n_state = fct_pkg::ST_OUT;
            fct_pkg::ST_OUT:
                if (out_fire) n_state = fct_pkg::ST_IDLE;
            default:           n_state = fct_pkg::ST_IDLE;
        endcase
    end

    // entry update arithmetic
    always_comb begin
        e = r_new ? '0 : r_ent;
        gap = r_req.now - e.last_time;
        nn = e.normal + {31'd0, !r_req.flagged};
        nf = e.flagged + {31'd0, r_req.flagged};
        cong = (gap < {32'd0, i_interval_limit}) || (nf >= {24'd0, i_retransmit_limit});
        ninc = r_notify + 32'd1;
        upd = e;
        upd.last_time = r_req.now;
        upd.normal = nn;
        upd.flagged = nf;
        if (cong) begin
            if (e.start == '0) upd.start = r_req.now;
        end else begin
            upd.start = '0;
        end
        held = r_req.now - upd.start;
        w2 = {1'b0, e.window[31:1]};
        if (upd.start != '0 && held >= i_hold_time) begin
            if (e.wset) upd.window = (w2 == '0) ? 32'd1 : w2;
            else begin
                upd.window = {16'd0, i_initial_window};
                upd.wset = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fct_pkg::ST_IDLE;
            r_used <= '0;
            r_notify <= '0;
            r_outv <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take) r_hit <= 1'b0;
            else if (hit_now) r_hit <= 1'b1;
            if (r_state == fct_pkg::ST_CALC && (r_hit || r_new)) begin
                if (cong) r_notify <= (ninc > i_notify_limit) ? 32'd1 : ninc;
                else r_notify <= '0;
            end
            if (r_state == fct_pkg::ST_WRITE && r_new) r_used <= r_used + CW'(1);
            if (out_fire) r_outv <= 1'b1;
            else if (r_outv && i_ready) r_outv <= 1'b0;
        end
    end

    // request capture, search walk one key per cycle with registered read, entry read and update
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req <= i_req;
            r_idx <= '0;
            r_new <= 1'b0;
        end else if (r_state == fct_pkg::ST_SEARCH) begin
            if (hit_now) r_slot <= AW'(r_idx - CW'(1));
            else if (r_idx >= r_used) r_slot <= AW'(r_used);
            else r_idx <= r_idx + CW'(1);
        end else if (r_state == fct_pkg::ST_READ) begin
            // a miss with a full table is not inserted
            r_new <= !r_hit && (r_used != Full);
        end
        r_keyrd <= m_key[AW'(r_idx)];
        r_ent <= m_ent[r_slot];
        if (r_state == fct_pkg::ST_CALC) begin
            r_upd <= upd;
            r_cong <= cong;
        end
    end

    // table writes
    always_ff @(posedge i_clk) begin
        if (r_state == fct_pkg::ST_WRITE && (r_hit || r_new)) begin
            m_ent[r_slot] <= r_upd;
            if (r_new) m_key[r_slot] <= r_req.key;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            if (r_req.watch && (r_hit || r_new)) begin
                r_out <= {r_upd.flagged, r_upd.normal,
                          r_upd.wset ? r_upd.window : 32'd0,
                          r_upd.wset, r_notify, r_cong, 1'b1};
            end else begin
                r_out <= {96'd0, 1'b0, r_notify, 2'b00};
            end
        end
    end

    assign o_valid = r_outv;
    assign o_data = r_out;

    `CHK_ALWAYS(a_used_max, i_clk, i_rst_n, r_used <= Full, "table fill count overflow")
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, r_outv && !i_ready, r_outv, "result dropped before taken")
    `CHK_ALWAYS(a_no_accept_busy, i_clk, i_rst_n, !(take && (r_state != fct_pkg::ST_IDLE)), "request accepted while busy")
endmodule
`default_nettype wire

// ----- design/flow_congestion_tracker.sv -----
// Flow congestion tracker: per-source TCP congestion bookkeeping.
// A watched packet passes a linear key search over the entries in use, then
// the read, calc, write and output states; others go from search to output.
// The back end takes one packet at a time; the front queue accepts two ahead.
// Reset: synchronous active low; clears the fill count, notify counter and
// registers to defaults; no clearing pass is needed.
`default_nettype none
module flow_congestion_tracker #(
    parameter int unsigned FLOW_ENTRIES = fct_pkg::FlowEntries
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // frame_length, ip_protocol, source_address, source_port, dest_port,
    // flag_syn, flag_rst, flag_fin, time_ns; zero padded
    input  wire logic [159:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // tracked, congested, notify_count, window_valid, window_size,
    // normal_count, flagged_count; zero padded
    output logic [135:0]       m_axis_tdata,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [63:0]   i_cfg_data
);
    logic [31:0] r_interval;
    logic [7:0]  r_retx;
    logic [31:0] r_nlimit;
    logic [63:0] r_hold;
    logic [15:0] r_port;
    logic [15:0] r_iwin;
    logic          req_valid, req_ready;
    fct_pkg::t_req req;
    logic [130:0]  out_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= fct_pkg::RstIntervalLimit;
            r_retx <= fct_pkg::RstRetransmitLimit;
            r_nlimit <= fct_pkg::RstNotifyLimit;
            r_hold <= fct_pkg::RstHoldTime;
            r_port <= fct_pkg::RstWatchedPort;
            r_iwin <= fct_pkg::RstInitialWindow;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fct_pkg::CfgIntervalLimit:   r_interval <= i_cfg_data[31:0];
                fct_pkg::CfgRetransmitLimit: r_retx <= i_cfg_data[7:0];
                fct_pkg::CfgNotifyLimit:     r_nlimit <= i_cfg_data[31:0];
                fct_pkg::CfgHoldTime:        r_hold <= i_cfg_data;
                fct_pkg::CfgWatchedPort:     r_port <= i_cfg_data[15:0];
                fct_pkg::CfgInitialWindow:   r_iwin <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    fct_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_frame_length(s_axis_tdata[15:0]), .i_ip_protocol(s_axis_tdata[23:16]),
        .i_source_address(s_axis_tdata[55:24]), .i_source_port(s_axis_tdata[71:56]),
        .i_dest_port(s_axis_tdata[87:72]),
        .i_flag(s_axis_tdata[88] | s_axis_tdata[89] | s_axis_tdata[90]),
        .i_time_ns(s_axis_tdata[154:91]), .i_watched_port(r_port),
        .o_req_valid(req_valid), .i_req_ready(req_ready), .o_req(req)
    );

    fct_back #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(req_valid), .o_req_ready(req_ready), .i_req(req),
        .i_interval_limit(r_interval), .i_retransmit_limit(r_retx),
        .i_notify_limit(r_nlimit), .i_hold_time(r_hold), .i_initial_window(r_iwin),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(out_data)
    );

    assign m_axis_tdata = {5'd0, out_data};
endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// testbench for flow_congestion_tracker: directed table, random packets per config phase,
// then a filled table; depends on fct_pkg and the flow_congestion_tracker rtl
`timescale 1ns / 1ps
module tb_top;
    localparam int unsigned CycleLimit = 10000000;
    localparam int unsigned DrainCycles = 1200;

    typedef struct {
        logic [15:0] frame_len;
        logic [7:0]  proto;
        logic [31:0] saddr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic        syn;
        logic        rst;
        logic        fin;
        logic [63:0] now;
    } t_pkt;

    typedef struct {
        logic        tracked;
        logic        congested;
        logic [31:0] notify;
        logic        win_valid;
        logic [31:0] win_size;
        logic [31:0] normal;
        logic [31:0] flagged;
    } t_res;

    typedef struct {
        t_pkt pkt;
        logic typed;
        t_res res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // frame_length, ip_protocol, source_address, source_port, dest_port,
    // flag_syn, flag_rst, flag_fin, time_ns; zero padded
    logic [159:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // tracked, congested, notify_count, window_valid, window_size,
    // normal_count, flagged_count; zero padded
    logic [135:0] m_axis_tdata;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    flow_congestion_tracker i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // tracker configuration copy
    logic [31:0] interval_lim;
    logic [7:0]  retx_lim;
    logic [31:0] notify_lim;
    logic [63:0] hold_ns;
    logic [15:0] port_watch;
    logic [15:0] init_win;

    // flow table copy
    logic            flow_valid [fct_pkg::FlowEntries];
    logic [31:0]     flow_key [fct_pkg::FlowEntries];
    fct_pkg::t_entry flow_ent [fct_pkg::FlowEntries];
    logic [31:0]     notify_cnt;
    int unsigned     flows_used;

    t_res pending_results[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned tx_idle_pct = 24;
    int unsigned rx_idle_pct = 84;
    logic [63:0] clock_ns = '0;
    logic [31:0] addr_pool [16];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // expected bookkeeping for one packet
    function automatic t_res track_packet(input t_pkt p);
        t_res r;
        int slot;
        logic [63:0] gap;
        logic cong;
        slot = -1;
        r = '{default: '0};
        if (p.frame_len >= fct_pkg::MinFrameBytes && p.proto == fct_pkg::ProtoTcp &&
            (p.sport == port_watch || p.dport == port_watch)) begin
            for (int i = 0; i < flows_used; i++) begin
                if (flow_valid[i] && flow_key[i] == p.saddr && slot < 0) slot = i;
            end
            if (slot < 0 && flows_used < fct_pkg::FlowEntries) begin
                slot = flows_used;
                flows_used++;
                flow_valid[slot] = 1'b1;
                flow_key[slot] = p.saddr;
                flow_ent[slot] = '0;
            end
        end
        if (slot < 0) begin
            r.notify = notify_cnt;
            return r;
        end
        gap = p.now - flow_ent[slot].last_time;
        flow_ent[slot].last_time = p.now;
        if (p.syn | p.rst | p.fin) flow_ent[slot].flagged++;
        else flow_ent[slot].normal++;
        cong = (gap < {32'd0, interval_lim}) || (flow_ent[slot].flagged >= {24'd0, retx_lim});
        if (cong) begin
            notify_cnt++;
            if (notify_cnt > notify_lim) notify_cnt = 32'd1;
            if (flow_ent[slot].start == 64'd0) flow_ent[slot].start = p.now;
        end else begin
            flow_ent[slot].start = '0;
            notify_cnt = '0;
        end
        if (flow_ent[slot].start != 64'd0 && p.now - flow_ent[slot].start >= hold_ns) begin
            if (flow_ent[slot].wset) begin
                flow_ent[slot].window = flow_ent[slot].window / 2;
                if (flow_ent[slot].window < 32'd1) flow_ent[slot].window = 32'd1;
            end else begin
                flow_ent[slot].window = {16'd0, init_win};
                flow_ent[slot].wset = 1'b1;
            end
        end
        r.tracked = 1'b1;
        r.congested = cong;
        r.notify = notify_cnt;
        r.win_valid = flow_ent[slot].wset;
        r.win_size = flow_ent[slot].wset ? flow_ent[slot].window : 32'd0;
        r.normal = flow_ent[slot].normal;
        r.flagged = flow_ent[slot].flagged;
        return r;
    endfunction

    // drive one request and wait for its acceptance; valid stays up until the next call
    task automatic send_packet(input t_pkt p, input logic typed, input t_res want);
        t_res r;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, p.now, p.fin, p.rst, p.syn, p.dport, p.sport,
                         p.saddr, p.proto, p.frame_len};
        do @(posedge i_clk); while (!s_axis_tready);
        r = track_packet(p);
        pending_results.push_back(typed ? want : r);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        case (idx)
            fct_pkg::CfgIntervalLimit: interval_lim = val[31:0];
            fct_pkg::CfgRetransmitLimit: retx_lim = val[7:0];
            fct_pkg::CfgNotifyLimit: notify_lim = val[31:0];
            fct_pkg::CfgHoldTime: hold_ns = val;
            fct_pkg::CfgWatchedPort: port_watch = val[15:0];
            fct_pkg::CfgInitialWindow: init_win = val[15:0];
            default: ;
        endcase
    endtask

    // wait until the tracker has nothing in flight
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic load_config(input logic [31:0] iv, input logic [7:0] rt,
                               input logic [31:0] nl, input logic [63:0] ht,
                               input logic [15:0] wp, input logic [15:0] iw);
        wait_idle();
        write_reg(fct_pkg::CfgIntervalLimit, {32'd0, iv});
        write_reg(fct_pkg::CfgRetransmitLimit, {56'd0, rt});
        write_reg(fct_pkg::CfgNotifyLimit, {32'd0, nl});
        write_reg(fct_pkg::CfgHoldTime, ht);
        write_reg(fct_pkg::CfgWatchedPort, {48'd0, wp});
        write_reg(fct_pkg::CfgInitialWindow, {48'd0, iw});
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_pkt mk_pkt(input logic [15:0] fl, input logic [7:0] pr,
                                    input logic [31:0] sa, input logic [15:0] sp,
                                    input logic [15:0] dp, input logic [2:0] flg,
                                    input logic [63:0] tm);
        t_pkt p;
        p = '{fl, pr, sa, sp, dp, flg[0], flg[1], flg[2], tm};
        return p;
    endfunction

    // random packet, mostly watched tcp from a small set of sources
    function automatic t_pkt rand_pkt();
        t_pkt p;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40)
            clock_ns += 64'($urandom_range(interval_lim > 0 ? 2 * interval_lim : 100));
        else if (pick < 75) clock_ns += {$urandom_range(3), $urandom};
        else if (pick < 92) clock_ns += 64'($urandom_range(50));
        else if (pick < 96) clock_ns = {$urandom, $urandom};
        else clock_ns = '0;
        p.now = clock_ns;
        p.frame_len = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1500, 54));
        if ($urandom_range(19) == 0) p.frame_len = $urandom_range(1) ? 16'd53 : 16'd54;
        p.proto = ($urandom_range(14) == 0) ? 8'($urandom) : fct_pkg::ProtoTcp;
        p.saddr = ($urandom_range(49) == 0) ? $urandom : addr_pool[$urandom_range(15)];
        p.sport = 16'($urandom);
        p.dport = 16'($urandom);
        pick = $urandom_range(9);
        if (pick < 4) p.dport = port_watch;
        else if (pick < 8) p.sport = port_watch;
        else if (pick < 9) begin
            p.sport = port_watch;
            p.dport = port_watch;
        end
        p.syn = ($urandom_range(9) < 2);
        p.rst = ($urandom_range(9) < 2);
        p.fin = ($urandom_range(9) < 2);
        return p;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_res want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("unexpected result %0h at %0t", m_axis_tdata, $realtime);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[0] !== want.tracked)
                    report_mismatch("tracked", 32'(m_axis_tdata[0]), 32'(want.tracked));
                if (m_axis_tdata[1] !== want.congested)
                    report_mismatch("congested", 32'(m_axis_tdata[1]), 32'(want.congested));
                if (m_axis_tdata[33:2] !== want.notify)
                    report_mismatch("notify_count", m_axis_tdata[33:2], want.notify);
                if (m_axis_tdata[34] !== want.win_valid)
                    report_mismatch("window_valid", 32'(m_axis_tdata[34]), 32'(want.win_valid));
                if (m_axis_tdata[66:35] !== want.win_size)
                    report_mismatch("window_size", m_axis_tdata[66:35], want.win_size);
                if (m_axis_tdata[98:67] !== want.normal)
                    report_mismatch("normal_count", m_axis_tdata[98:67], want.normal);
                if (m_axis_tdata[130:99] !== want.flagged)
                    report_mismatch("flagged_count", m_axis_tdata[130:99], want.flagged);
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("[flow_congestion_tracker] ERROR");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_res z;
        t_pkt p;
        int unsigned fill_addr;

        interval_lim = fct_pkg::RstIntervalLimit;
        retx_lim = fct_pkg::RstRetransmitLimit;
        notify_lim = fct_pkg::RstNotifyLimit;
        hold_ns = fct_pkg::RstHoldTime;
        port_watch = fct_pkg::RstWatchedPort;
        init_win = fct_pkg::RstInitialWindow;
        for (int i = 0; i < fct_pkg::FlowEntries; i++) flow_valid[i] = 1'b0;
        notify_cnt = '0;
        flows_used = 0;
        for (int i = 0; i < 14; i++) addr_pool[i] = $urandom;
        addr_pool[14] = 32'h0;
        addr_pool[15] = 32'hFFFF_FFFF;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: filters, field extremes, time zero start, window set and halving
        z = '{default: '0};
        rows.push_back('{mk_pkt(16'd53, fct_pkg::ProtoTcp, 32'h1, 16'd1935, 16'd1935, 3'b000,
                         64'd100), 1'b1, z});
        rows.push_back('{mk_pkt(16'd54, 8'd17, 32'h1, 16'd1935, 16'd1935, 3'b000,
                         64'd100), 1'b1, z});
        rows.push_back('{mk_pkt(16'hFFFF, 8'hFF, 32'h1, 16'd1935, 16'd0, 3'b111,
                         64'd100), 1'b1, z});
        rows.push_back('{mk_pkt(16'hFFFF, fct_pkg::ProtoTcp, 32'h1, 16'd0, 16'hFFFF, 3'b000,
                         64'd100), 1'b1, z});
        rows.push_back('{mk_pkt(16'd54, fct_pkg::ProtoTcp, 32'h0, 16'd1935, 16'd0, 3'b000,
                         64'd0), 1'b1, '{1, 1, 32'd1, 0, 32'd0, 32'd1, 32'd0}});
        rows.push_back('{mk_pkt(16'd54, fct_pkg::ProtoTcp, 32'h0, 16'd0, 16'd1935, 3'b001,
                         64'd0), 1'b1, '{1, 1, 32'd2, 0, 32'd0, 32'd1, 32'd1}});
        rows.push_back('{mk_pkt(16'd60, fct_pkg::ProtoTcp, 32'hFFFF_FFFF, 16'hFFFF, 16'd1935,
                         3'b110, 64'hFFFF_FFFF_FFFF_FFFF), 1'b1,
                         '{1, 0, 32'd0, 0, 32'd0, 32'd0, 32'd1}});
        rows.push_back('{mk_pkt(16'd80, fct_pkg::ProtoTcp, 32'h0, 16'd1935, 16'd80, 3'b000,
                         64'd5000000), 1'b0, z});
        rows.push_back('{mk_pkt(16'd80, fct_pkg::ProtoTcp, 32'h0, 16'd1935, 16'd80, 3'b100,
                         64'd5000010), 1'b0, z});
        rows.push_back('{mk_pkt(16'd80, fct_pkg::ProtoTcp, 32'h0, 16'd1935, 16'd80, 3'b010,
                         64'd20000000000), 1'b0, z});
        rows.push_back('{mk_pkt(16'd80, fct_pkg::ProtoTcp, 32'h0, 16'd1935, 16'd80, 3'b000,
                         64'd40000000000), 1'b0, z});
        rows.push_back('{mk_pkt(16'd80, fct_pkg::ProtoTcp, 32'h0, 16'd1935, 16'd80, 3'b001,
                         64'd50000000000), 1'b0, z});
        rows.push_back('{mk_pkt(16'd80, fct_pkg::ProtoTcp, 32'h0, 16'd1935, 16'd80, 3'b000,
                         64'd50000000001), 1'b0, z});
        rows.push_back('{mk_pkt(16'd54, fct_pkg::ProtoTcp, 32'h1234_5678, 16'd1935, 16'd1935,
                         3'b111, 64'd7), 1'b0, z});
        rows.push_back('{mk_pkt(16'd1500, fct_pkg::ProtoTcp, 32'hA5A5_5A5A, 16'hFFFF, 16'hFFFF,
                         3'b000, 64'd7), 1'b0, z});
        foreach (rows[i]) send_packet(rows[i].pkt, rows[i].typed, rows[i].res);

        // random phases over several register settings and idle patterns
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: ;
                1: load_config(32'd0, 8'd0, 32'd0, 64'd0, 16'd0, 16'd0);
                2: load_config(32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                               16'hFFFF, 16'hFFFF);
                3: load_config(32'd2000, 8'd4, 32'd3, 64'd3000000000, 16'd80, 16'd64);
                4: load_config($urandom_range(100000), 8'($urandom_range(6)),
                               $urandom_range(20), {$urandom_range(1), $urandom},
                               16'($urandom), 16'($urandom));
                default: load_config(32'd1000000, 8'd3, 32'd10, 64'd10000000000,
                                     16'd1935, 16'd1);
            endcase
            tx_idle_pct = (ph < 2) ? 24 : (ph < 4) ? 84 : 0;
            rx_idle_pct = (ph < 2) ? 84 : (ph < 4) ? 24 : 0;
            for (int n = 0; n < 80; n++) begin
                p = rand_pkt();
                send_packet(p, 1'b0, z);
            end
        end

        // fill the table, then unknown sources are ignored while known ones still track
        fill_addr = 32'h0A00_0000;
        while (flows_used < fct_pkg::FlowEntries) begin
            p = mk_pkt(16'd64, fct_pkg::ProtoTcp, fill_addr, 16'd1935, 16'd1, 3'b000, clock_ns);
            clock_ns += 64'd1000;
            fill_addr++;
            send_packet(p, 1'b0, z);
        end
        for (int n = 0; n < 30; n++) begin
            p = mk_pkt(16'd64, fct_pkg::ProtoTcp,
                       (n % 2) ? $urandom : addr_pool[$urandom_range(15)],
                       16'd1935, 16'd1, 3'($urandom), clock_ns);
            clock_ns += 64'($urandom_range(2000000));
            send_packet(p, 1'b0, z);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("[flow_congestion_tracker] OK");
        end else begin
            $display("[flow_congestion_tracker] ERROR");
        end
        $finish;
    end
endmodule
